// File: hdl/sc1a_pkg.sv
// Package for the set-1 scan byte decoder: byte codes and the character ROM.
package sc1a_pkg;

    // Scan byte codes
    localparam logic [7:0] C_PREFIX_E0   = 8'hE0;
    localparam logic [6:0] C_KEY_CTRL    = 7'h1D;
    localparam logic [6:0] C_KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] C_KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] C_KEY_ALT     = 7'h38;
    localparam logic [6:0] C_KEY_CAPS    = 7'h3A;
    localparam logic [7:0] C_ROM_ROWS    = 8'h3B;

    typedef logic [6:0] t_ascii;
    typedef logic [5:0] t_rom_idx;

    // Keys whose column follows shift alone (digits, punctuation, controls)
    function automatic logic shift_only_key(input t_rom_idx idx);
        return (idx < 6'h0E) || (idx inside {6'h1A, 6'h1B, 6'h27, 6'h28, 6'h29,
                                             6'h2B, 6'h33, 6'h34, 6'h35});
    endfunction

    // Character ROM: column 0 unshifted, column 1 shifted; zero means no character
    function automatic t_ascii rom_char(input t_rom_idx idx, input logic col);
        logic [13:0] pair;
        unique case (idx)
            6'h01: pair = {7'h1B, 7'h1B};
            6'h02: pair = {7'h31, 7'h21};
            6'h03: pair = {7'h32, 7'h40};
            6'h04: pair = {7'h33, 7'h23};
            6'h05: pair = {7'h34, 7'h24};
            6'h06: pair = {7'h35, 7'h25};
            6'h07: pair = {7'h36, 7'h5E};
            6'h08: pair = {7'h37, 7'h26};
            6'h09: pair = {7'h38, 7'h2A};
            6'h0A: pair = {7'h39, 7'h28};
            6'h0B: pair = {7'h30, 7'h29};
            6'h0C: pair = {7'h2D, 7'h5F};
            6'h0D: pair = {7'h3D, 7'h2B};
            6'h0E: pair = {7'h08, 7'h08};
            6'h0F: pair = {7'h09, 7'h09};
            6'h10: pair = {7'h71, 7'h51};
            6'h11: pair = {7'h77, 7'h57};
            6'h12: pair = {7'h65, 7'h45};
            6'h13: pair = {7'h72, 7'h52};
            6'h14: pair = {7'h74, 7'h54};
            6'h15: pair = {7'h79, 7'h59};
            6'h16: pair = {7'h75, 7'h55};
            6'h17: pair = {7'h69, 7'h49};
            6'h18: pair = {7'h6F, 7'h4F};
            6'h19: pair = {7'h70, 7'h50};
            6'h1A: pair = {7'h5B, 7'h7B};
            6'h1B: pair = {7'h5D, 7'h7D};
            6'h1C: pair = {7'h0D, 7'h0D};
            6'h1E: pair = {7'h61, 7'h41};
            6'h1F: pair = {7'h73, 7'h53};
            6'h20: pair = {7'h64, 7'h44};
            6'h21: pair = {7'h66, 7'h46};
            6'h22: pair = {7'h67, 7'h47};
            6'h23: pair = {7'h68, 7'h48};
            6'h24: pair = {7'h6A, 7'h4A};
            6'h25: pair = {7'h6B, 7'h4B};
            6'h26: pair = {7'h6C, 7'h4C};
            6'h27: pair = {7'h3B, 7'h3A};
            6'h28: pair = {7'h27, 7'h22};
            6'h29: pair = {7'h60, 7'h7E};
            6'h2B: pair = {7'h5C, 7'h7C};
            6'h2C: pair = {7'h7A, 7'h5A};
            6'h2D: pair = {7'h78, 7'h58};
            6'h2E: pair = {7'h63, 7'h43};
            6'h2F: pair = {7'h76, 7'h56};
            6'h30: pair = {7'h62, 7'h42};
            6'h31: pair = {7'h6E, 7'h4E};
            6'h32: pair = {7'h6D, 7'h4D};
            6'h33: pair = {7'h2C, 7'h3C};
            6'h34: pair = {7'h2E, 7'h3E};
            6'h35: pair = {7'h2F, 7'h3F};
            6'h37: pair = {7'h2A, 7'h2A};
            6'h39: pair = {7'h20, 7'h20};
            default: pair = 14'h0000;
        endcase
        return col ? pair[6:0] : pair[13:7];
    endfunction

endpackage

// File: hdl/scancode_set1_to_ascii_top.sv
// Result valid rises in the result register in the cycle after an input transfer.
// Throughput: one byte per cycle; the key-state flags update in the accepting cycle,
// so the next byte sees them at once; the result register stalls only on output back pressure.
// Reset (i_rst_n, synchronous, active low) clears prefix, ctrl, shift, caps and result valid.
// Result payload registers carry no reset.
module scancode_set1_to_ascii_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_char_valid,
    output logic [6:0] o_ascii_char,
    output logic       o_unknown_key,
    output logic       o_ctrl_down,
    output logic       o_shift_down,
    output logic       o_caps_on
);
    import sc1a_pkg::*;

    logic   r_prefix, n_prefix;
    logic   r_ctrl,   n_ctrl;
    logic   r_shift,  n_shift;
    logic   r_caps,   n_caps;
    logic   r_out_valid;
    t_ascii r_char;
    logic   r_unknown;
    logic   r_ctrl_out, r_shift_out, r_caps_out;

    logic   in_xfer;
    logic   handled;
    logic   col;
    t_ascii ch;
    logic   unknown;

    // Accept a new byte whenever the result register is empty or draining
    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;

    // Decode one byte against the current key state
    always_comb begin
        n_prefix = r_prefix;
        n_ctrl   = r_ctrl;
        n_shift  = r_shift;
        n_caps   = r_caps;
        ch       = '0;
        unknown  = 1'b0;
        handled  = r_prefix ? (i_scan_byte[6:0] == C_KEY_CTRL || i_scan_byte[6:0] == C_KEY_ALT)
                            : (i_scan_byte != 8'h00 && i_scan_byte < C_ROM_ROWS);
        col      = (shift_only_key(i_scan_byte[5:0]) && !r_prefix) ? r_shift
                                                                     : (r_shift ^ r_caps);
        if (i_scan_byte == C_PREFIX_E0) begin
            n_prefix = 1'b1;
        end else begin
            n_prefix = 1'b0;
            if (i_scan_byte[7]) begin
                // Break code: release ctrl, or shift when unprefixed
                if (i_scan_byte[6:0] == C_KEY_CTRL) begin
                    n_ctrl = 1'b0;
                end else if (!r_prefix && (i_scan_byte[6:0] == C_KEY_LSHIFT ||
                                           i_scan_byte[6:0] == C_KEY_RSHIFT)) begin
                    n_shift = 1'b0;
                end
            end else if (handled) begin
                ch = rom_char(i_scan_byte[5:0], col);
                // Modifier make codes have no character
                if (ch == '0) begin
                    if (i_scan_byte[6:0] == C_KEY_CTRL) begin
                        n_ctrl = 1'b1;
                    end else if (i_scan_byte[6:0] == C_KEY_LSHIFT ||
                                 i_scan_byte[6:0] == C_KEY_RSHIFT) begin
                        n_shift = 1'b1;
                    end else if (i_scan_byte[6:0] == C_KEY_CAPS) begin
                        n_caps = !r_caps;
                    end
                end
            end else begin
                unknown = 1'b1;
            end
        end
    end

    // Advance key state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_ctrl   <= 1'b0;
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
        end else if (in_xfer) begin
            r_prefix <= n_prefix;
            r_ctrl   <= n_ctrl;
            r_shift  <= n_shift;
            r_caps   <= n_caps;
        end
    end

    // Hold result valid until the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char      <= ch;
            r_unknown   <= unknown;
            r_ctrl_out  <= n_ctrl;
            r_shift_out <= n_shift;
            r_caps_out  <= n_caps;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_char_valid  = (r_char != '0);
    assign o_ascii_char  = r_char;
    assign o_unknown_key = r_unknown;
    assign o_ctrl_down   = r_ctrl_out;
    assign o_shift_down  = r_shift_out;
    assign o_caps_on     = r_caps_out;

endmodule
